FILE: design/cbb_pkg.sv
// Shared types and constants of the clipped box blur unit.
// No dependencies; every other design file but cbb_ram refers to this package by scoped names.
`default_nettype none
package cbb_pkg;

  localparam int unsigned MAX_WIDTH   = 1024;
  localparam int unsigned MAX_HALF    = 7;
  localparam int unsigned ROW_LIMIT   = 1024;
  localparam int unsigned STORE_DEPTH = (2 * MAX_HALF + 1) * MAX_WIDTH;

  localparam int unsigned CFG_W   = 11;
  localparam int unsigned POS_W   = 10;
  localparam int unsigned HALF_W  = $clog2(MAX_HALF + 1);
  localparam int unsigned IDX_W   = 20;
  localparam int unsigned ADDR_W  = $clog2(STORE_DEPTH);
  localparam int unsigned PIX_W   = 8;
  localparam int unsigned SUM_W   = 16;
  localparam int unsigned CNT_W   = 8;

  localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [1:0] REG_KERNEL_SIZE  = 2'd2;

  // Clamped frame geometry seen by the datapath.
  typedef struct packed {
    logic [CFG_W-1:0]  width;
    logic [CFG_W-1:0]  height;
    logic [HALF_W-1:0] half;
    logic [IDX_W-1:0]  lag;
  } geom_t;

  // One output job handed from the front to the back.
  typedef struct packed {
    logic [POS_W-1:0]  row;
    logic [POS_W-1:0]  col;
    logic [IDX_W-1:0]  newest_idx;
    logic [ADDR_W-1:0] newest_addr;
    logic              last;
  } job_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [PIX_W-1:0]  data;
  } store_wr_t;

endpackage
`default_nettype wire

FILE: design/cbb_if.sv
// Handshake interfaces for the input and result channels of the blur unit.
// Depends on cbb_pkg for field widths.
`default_nettype none
interface cbb_in_if;
  logic                        valid;
  logic                        ready;
  logic                        cmd;
  logic [cbb_pkg::PIX_W-1:0]   pixel_in;
  modport source (output valid, output cmd, output pixel_in, input ready);
  modport sink   (input valid, input cmd, input pixel_in, output ready);
endinterface

interface cbb_out_if;
  logic                        valid;
  logic                        ready;
  logic [cbb_pkg::PIX_W-1:0]   mean_out;
  logic                        frame_end;
  modport source (output valid, output mean_out, output frame_end, input ready);
  modport sink   (input valid, input mean_out, input frame_end, output ready);
endinterface
`default_nettype wire

FILE: design/cbb_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module cbb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

FILE: design/cbb_job_fifo.sv
// Two-entry queue of output jobs between the front and the back.
// Depends on cbb_pkg for the job type.
`default_nettype none
module cbb_job_fifo (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire cbb_pkg::job_t push_data_i,
  output logic               full_o,
  input  wire logic          pop_i,
  output logic               valid_o,
  output cbb_pkg::job_t      pop_data_o
);
  cbb_pkg::job_t mem_q [2];
  logic          wr_ptr_q, rd_ptr_q;
  logic [1:0]    count_q;

  assign full_o     = (count_q == 2'd2);
  assign valid_o    = (count_q != 2'd0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i)  rd_ptr_q <= ~rd_ptr_q;
      if (push_i && !pop_i)      count_q <= count_q + 2'd1;
      else if (!push_i && pop_i) count_q <= count_q - 2'd1;
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i || pop_i) else $error("job queue overflow");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o) else $error("job queue underflow");
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != 2'd3) else $error("job queue count out of range");
`endif
endmodule
`default_nettype wire

FILE: design/cbb_front.sv
// Front end: accepts items, writes pixels into the line store and queues output jobs.
// Depends on cbb_pkg and cbb_if.
`default_nettype none
module cbb_front (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  cbb_in_if.sink                   in_if,
  input  wire cbb_pkg::geom_t      geom_i,
  input  wire logic                cfg_clear_i,
  input  wire logic                fifo_full_i,
  output logic                     push_o,
  output cbb_pkg::job_t            job_o,
  output cbb_pkg::store_wr_t       store_wr_o
);
  logic [cbb_pkg::POS_W-1:0]  in_row_q, in_col_q, out_row_q, out_col_q;
  logic                       done_q;
  logic [cbb_pkg::IDX_W-1:0]  idx_q, last_idx_q;
  logic [cbb_pkg::ADDR_W-1:0] addr_q, last_addr_q;

  logic accept, is_pix, is_drain, emit, in_last, out_last;
  logic [cbb_pkg::CFG_W-1:0]  w_m1, h_m1;
  logic [cbb_pkg::ADDR_W:0]   addr_inc;

  assign in_if.ready = !fifo_full_i;
  assign accept      = in_if.valid && in_if.ready;
  assign is_pix      = !in_if.cmd && !done_q;
  assign is_drain    = in_if.cmd && done_q;
  assign emit        = is_pix ? (idx_q >= geom_i.lag) : is_drain;
  assign w_m1        = geom_i.width - 11'd1;
  assign h_m1        = geom_i.height - 11'd1;
  assign in_last     = ({1'b0, in_row_q} == h_m1) && ({1'b0, in_col_q} == w_m1);
  assign out_last    = ({1'b0, out_row_q} == h_m1) && ({1'b0, out_col_q} == w_m1);
  assign addr_inc    = {1'b0, addr_q} + 15'd1;

  assign push_o            = accept && emit;
  assign job_o.row         = out_row_q;
  assign job_o.col         = out_col_q;
  assign job_o.newest_idx  = is_pix ? idx_q : last_idx_q;
  assign job_o.newest_addr = is_pix ? addr_q : last_addr_q;
  assign job_o.last        = out_last;

  assign store_wr_o.we   = accept && is_pix;
  assign store_wr_o.addr = addr_q;
  assign store_wr_o.data = in_if.pixel_in;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_row_q    <= '0;
      in_col_q    <= '0;
      out_row_q   <= '0;
      out_col_q   <= '0;
      done_q      <= 1'b0;
      idx_q       <= '0;
      addr_q      <= '0;
      last_idx_q  <= '0;
      last_addr_q <= '0;
    end else if (cfg_clear_i) begin
      in_row_q  <= '0;
      in_col_q  <= '0;
      out_row_q <= '0;
      out_col_q <= '0;
      done_q    <= 1'b0;
      idx_q     <= '0;
      addr_q    <= '0;
    end else if (accept) begin
      if (emit && out_last) begin
        // The frame's last result returns every position to the start.
        in_row_q  <= '0;
        in_col_q  <= '0;
        out_row_q <= '0;
        out_col_q <= '0;
        done_q    <= 1'b0;
        idx_q     <= '0;
        addr_q    <= '0;
      end else begin
        if (is_pix) begin
          last_idx_q  <= idx_q;
          last_addr_q <= addr_q;
          idx_q       <= idx_q + 20'd1;
          if (addr_inc >= 15'(cbb_pkg::STORE_DEPTH)) addr_q <= '0;
          else                                       addr_q <= addr_inc[cbb_pkg::ADDR_W-1:0];
          if (in_last) begin
            done_q <= 1'b1;
          end else if ({1'b0, in_col_q} == w_m1) begin
            in_col_q <= '0;
            in_row_q <= in_row_q + 10'd1;
          end else begin
            in_col_q <= in_col_q + 10'd1;
          end
        end
        if (emit) begin
          if ({1'b0, out_col_q} == w_m1) begin
            out_col_q <= '0;
            out_row_q <= out_row_q + 10'd1;
          end else begin
            out_col_q <= out_col_q + 10'd1;
          end
        end
      end
    end
  end
endmodule
`default_nettype wire

FILE: design/cbb_back.sv
// Back end: walks the clipped window in the line store, sums it and divides by the count.
// Depends on cbb_pkg and cbb_if.
`default_nettype none
module cbb_back (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire cbb_pkg::geom_t            geom_i,
  input  wire logic                      job_valid_i,
  input  wire cbb_pkg::job_t             job_i,
  output logic                           pop_o,
  output logic [cbb_pkg::ADDR_W-1:0]     rd_addr_o,
  input  wire logic [cbb_pkg::PIX_W-1:0] rd_data_i,
  cbb_out_if.source                      out_if
);
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SETUP = 3'd1;
  localparam logic [2:0] ST_ADDR  = 3'd2;
  localparam logic [2:0] ST_READ  = 3'd3;
  localparam logic [2:0] ST_TAIL  = 3'd4;
  localparam logic [2:0] ST_DIV   = 3'd5;
  localparam logic [2:0] ST_OUT   = 3'd6;

  logic [2:0]                 state_q;
  logic [cbb_pkg::POS_W-1:0]  r0_q, r1_q, c0_q, c1_q, i_q, j_q;
  logic [cbb_pkg::IDX_W-1:0]  newest_idx_q;
  logic [cbb_pkg::ADDR_W-1:0] newest_addr_q, row_addr_q, rd_addr_q;
  logic                       last_q, rd_pend_q;
  logic [20:0]                prod_q;
  logic [cbb_pkg::SUM_W-1:0]  sum_q;
  logic [cbb_pkg::CNT_W-1:0]  cnt_q;
  logic [cbb_pkg::CNT_W:0]    rem_q;
  logic [4:0]                 div_step_q;
  logic                       out_valid_q, out_end_q;
  logic [cbb_pkg::PIX_W-1:0]  out_mean_q;

  logic [cbb_pkg::CFG_W-1:0]  r_plus, c_plus, w_m1, h_m1;
  logic [cbb_pkg::POS_W-1:0]  r0_d, r1_d, c0_d, c1_d;
  logic [21:0]                delta_full;
  logic [cbb_pkg::ADDR_W-1:0] delta;
  logic [cbb_pkg::ADDR_W:0]   col_step, row_step;
  logic [cbb_pkg::CNT_W:0]    rem_shift;
  logic                       out_free;

  assign w_m1   = geom_i.width - 11'd1;
  assign h_m1   = geom_i.height - 11'd1;
  assign r_plus = {1'b0, job_i.row} + 11'(geom_i.half);
  assign c_plus = {1'b0, job_i.col} + 11'(geom_i.half);
  assign r0_d   = (job_i.row > 10'(geom_i.half)) ? job_i.row - 10'(geom_i.half) : '0;
  assign c0_d   = (job_i.col > 10'(geom_i.half)) ? job_i.col - 10'(geom_i.half) : '0;
  assign r1_d   = (r_plus > h_m1) ? h_m1[cbb_pkg::POS_W-1:0] : r_plus[cbb_pkg::POS_W-1:0];
  assign c1_d   = (c_plus > w_m1) ? w_m1[cbb_pkg::POS_W-1:0] : c_plus[cbb_pkg::POS_W-1:0];

  // Distance back from the newest stored pixel to the window's first pixel.
  assign delta_full = {2'b0, newest_idx_q} - {1'b0, prod_q} - {12'b0, c0_q};
  assign delta      = delta_full[cbb_pkg::ADDR_W-1:0];

  assign col_step  = {1'b0, rd_addr_q} + 15'd1;
  assign row_step  = {1'b0, row_addr_q} + 15'(geom_i.width);
  assign rem_shift = {rem_q[cbb_pkg::CNT_W-1:0], sum_q[cbb_pkg::SUM_W-1]};
  assign out_free  = !out_valid_q || out_if.ready;

  assign pop_o     = (state_q == ST_IDLE) && job_valid_i;
  assign rd_addr_o = rd_addr_q;

  assign out_if.valid     = out_valid_q;
  assign out_if.mean_out  = out_mean_q;
  assign out_if.frame_end = out_end_q;

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        r0_q          <= r0_d;
        r1_q          <= r1_d;
        c0_q          <= c0_d;
        c1_q          <= c1_d;
        newest_idx_q  <= job_i.newest_idx;
        newest_addr_q <= job_i.newest_addr;
        last_q        <= job_i.last;
      end
      ST_SETUP: begin
        prod_q <= r0_q * geom_i.width;
      end
      ST_ADDR: begin
        if (newest_addr_q < delta) begin
          row_addr_q <= 14'(newest_addr_q + 14'(cbb_pkg::STORE_DEPTH) - delta);
          rd_addr_q  <= 14'(newest_addr_q + 14'(cbb_pkg::STORE_DEPTH) - delta);
        end else begin
          row_addr_q <= newest_addr_q - delta;
          rd_addr_q  <= newest_addr_q - delta;
        end
        i_q   <= r0_q;
        j_q   <= c0_q;
        sum_q <= '0;
        cnt_q <= '0;
      end
      ST_READ: begin
        if (j_q == c1_q) begin
          i_q <= i_q + 10'd1;
          j_q <= c0_q;
          if (row_step >= 15'(cbb_pkg::STORE_DEPTH)) begin
            row_addr_q <= 14'(row_step - 15'(cbb_pkg::STORE_DEPTH));
            rd_addr_q  <= 14'(row_step - 15'(cbb_pkg::STORE_DEPTH));
          end else begin
            row_addr_q <= row_step[cbb_pkg::ADDR_W-1:0];
            rd_addr_q  <= row_step[cbb_pkg::ADDR_W-1:0];
          end
        end else begin
          j_q <= j_q + 10'd1;
          if (col_step >= 15'(cbb_pkg::STORE_DEPTH)) rd_addr_q <= '0;
          else rd_addr_q <= col_step[cbb_pkg::ADDR_W-1:0];
        end
      end
      ST_TAIL: begin
        rem_q <= '0;
      end
      ST_DIV: begin
        // Restoring division: one quotient bit per cycle, shifted into sum_q.
        if (rem_shift >= {1'b0, cnt_q}) begin
          rem_q <= rem_shift - {1'b0, cnt_q};
          sum_q <= {sum_q[cbb_pkg::SUM_W-2:0], 1'b1};
        end else begin
          rem_q <= rem_shift;
          sum_q <= {sum_q[cbb_pkg::SUM_W-2:0], 1'b0};
        end
      end
      default: begin
      end
    endcase
    if (rd_pend_q) begin
      sum_q <= sum_q + 16'(rd_data_i);
      cnt_q <= cnt_q + 8'd1;
    end
    if ((state_q == ST_OUT) && out_free) begin
      out_mean_q <= sum_q[cbb_pkg::PIX_W-1:0];
      out_end_q  <= last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rd_pend_q   <= 1'b0;
      div_step_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      rd_pend_q <= (state_q == ST_READ);
      case (state_q)
        ST_IDLE:  if (job_valid_i) state_q <= ST_SETUP;
        ST_SETUP: state_q <= ST_ADDR;
        ST_ADDR:  state_q <= ST_READ;
        ST_READ:  if ((j_q == c1_q) && (i_q == r1_q)) state_q <= ST_TAIL;
        ST_TAIL: begin
          state_q    <= ST_DIV;
          div_step_q <= '0;
        end
        ST_DIV: begin
          div_step_q <= div_step_q + 5'd1;
          if (div_step_q == 5'(cbb_pkg::SUM_W - 1)) state_q <= ST_OUT;
        end
        ST_OUT:   if (out_free) state_q <= ST_IDLE;
        default:  state_q <= ST_IDLE;
      endcase
      if ((state_q == ST_OUT) && out_free) out_valid_q <= 1'b1;
      else if (out_if.ready)               out_valid_q <= 1'b0;
    end
  end

`ifndef ASSERT_OFF
  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (cnt_q != '0)) else $error("division by a zero count");
  a_no_read_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> !rd_pend_q) else $error("store data arrived during division");
  a_window_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_READ) |-> (i_q <= r1_q) && (j_q <= c1_q))
    else $error("window walk left its bounds");
  a_pop_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> (state_q == ST_SETUP)) else $error("job taken without starting work");
`endif
endmodule
`default_nettype wire

FILE: design/clipped_box_blur_unit.sv
// Top level of the clipped box blur unit: configuration registers, front, job queue,
// back and the line store. Depends on cbb_pkg, cbb_if, cbb_ram, cbb_job_fifo,
// cbb_front and cbb_back.
//
// The unit takes a grayscale frame one 8-bit pixel per item in row-major order and
// returns, for each pixel, the truncated mean of the square window of half-size
// kernel_size/2 around it, clipped at the frame edges. Results trail the input by
// half*width + min(half, width-1) pixels; once the last pixel is in, drain items
// (cmd = 1) release the remaining results one per item, and frame_end marks the last.
// A drain item sent early and a pixel sent after the last one produce no result.
// The front writes each pixel into a 15360-entry line store and hands an output job
// to a two-entry queue; the back walks the clipped window through the store's single
// read port one pixel per cycle and then divides by the pixel count one quotient bit
// per cycle. The front keeps accepting items while the queue has room, and the output
// register lets the back finish the next result while one waits to be taken.
// Writing any defined configuration register restarts the frame; the store is not
// cleared and needs no clearing pass, since every read entry is written earlier in the
// same frame.
`default_nettype none
module clipped_box_blur_unit (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  cbb_in_if.sink                         in_if,
  cbb_out_if.source                      out_if,
  input  wire logic                      cfg_we_i,
  input  wire logic [1:0]                cfg_idx_i,
  input  wire logic [cbb_pkg::CFG_W-1:0] cfg_data_i
);
  logic [cbb_pkg::CFG_W-1:0] width_q, height_q;
  logic [3:0]                kernel_q;
  logic                      cfg_clear;
  cbb_pkg::geom_t            geom;
  logic [2:0]                half_raw;
  logic [cbb_pkg::CFG_W-1:0] w_m1, half_ext, lag_min;

  // Raw register writes; the clamped view below is what the datapath uses.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 11'd640;
      height_q <= 11'd480;
      kernel_q <= 4'd10;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        cbb_pkg::REG_FRAME_WIDTH:  width_q  <= cfg_data_i;
        cbb_pkg::REG_FRAME_HEIGHT: height_q <= cfg_data_i;
        cbb_pkg::REG_KERNEL_SIZE:  kernel_q <= cfg_data_i[3:0];
        default: begin
        end
      endcase
    end
  end

  // Only a write to a defined register restarts the frame.
  assign cfg_clear = cfg_we_i && ((cfg_idx_i == cbb_pkg::REG_FRAME_WIDTH) ||
                                  (cfg_idx_i == cbb_pkg::REG_FRAME_HEIGHT) ||
                                  (cfg_idx_i == cbb_pkg::REG_KERNEL_SIZE));

  always_comb begin
    if (width_q == '0)                               geom.width = 11'd1;
    else if (width_q > 11'(cbb_pkg::MAX_WIDTH))      geom.width = 11'(cbb_pkg::MAX_WIDTH);
    else                                             geom.width = width_q;
    if (height_q == '0)                              geom.height = 11'd1;
    else if (height_q > 11'(cbb_pkg::ROW_LIMIT))     geom.height = 11'(cbb_pkg::ROW_LIMIT);
    else                                             geom.height = height_q;
    half_raw = kernel_q[3:1];
    if (half_raw > 3'(cbb_pkg::MAX_HALF)) geom.half = cbb_pkg::HALF_W'(cbb_pkg::MAX_HALF);
    else                                  geom.half = cbb_pkg::HALF_W'(half_raw);
    w_m1     = geom.width - 11'd1;
    half_ext = 11'(geom.half);
    lag_min  = (half_ext < w_m1) ? half_ext : w_m1;
    // The product needs up to 13 bits, so both factors are widened first.
    geom.lag = cbb_pkg::IDX_W'(geom.half) * cbb_pkg::IDX_W'(geom.width) +
               cbb_pkg::IDX_W'(lag_min);
  end

  logic                  fifo_full, fifo_valid, push, pop;
  cbb_pkg::job_t         push_job, pop_job;
  cbb_pkg::store_wr_t    store_wr;
  logic [cbb_pkg::ADDR_W-1:0] rd_addr;
  logic [cbb_pkg::PIX_W-1:0]  rd_data;

  cbb_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_if       (in_if),
    .geom_i      (geom),
    .cfg_clear_i (cfg_clear),
    .fifo_full_i (fifo_full),
    .push_o      (push),
    .job_o       (push_job),
    .store_wr_o  (store_wr)
  );

  cbb_job_fifo u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_job),
    .full_o      (fifo_full),
    .pop_i       (pop),
    .valid_o     (fifo_valid),
    .pop_data_o  (pop_job)
  );

  cbb_ram #(
    .WIDTH (cbb_pkg::PIX_W),
    .DEPTH (cbb_pkg::STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (store_wr.we),
    .waddr_i (store_wr.addr),
    .wdata_i (store_wr.data),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  cbb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .geom_i      (geom),
    .job_valid_i (fifo_valid),
    .job_i       (pop_job),
    .pop_o       (pop),
    .rd_addr_o   (rd_addr),
    .rd_data_i   (rd_data),
    .out_if      (out_if)
  );

`ifndef ASSERT_OFF
  a_geom_width: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (geom.width != '0) && (geom.width <= 11'(cbb_pkg::MAX_WIDTH)))
    else $error("clamped width out of range");
  a_geom_height: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (geom.height != '0) && (geom.height <= 11'(cbb_pkg::ROW_LIMIT)))
    else $error("clamped height out of range");
  a_push_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> in_if.valid && in_if.ready) else $error("job queued without an accepted item");
`endif
endmodule
`default_nettype wire

FILE: verif/testbench.sv
// Self-checking testbench for the clipped box blur unit.
// Depends on cbb_pkg, cbb_if and the design's top level clipped_box_blur_unit.
`timescale 1ns / 100ps
`default_nettype none

// Predicts the blurred frame from accepted items and checks each result against it.
class blur_scoreboard;
  typedef struct {
    logic [cbb_pkg::PIX_W-1:0] mean;
    logic                      last;
  } blur_pix_t;

  logic [cbb_pkg::PIX_W-1:0] pix_store [cbb_pkg::STORE_DEPTH];
  int unsigned in_r, in_c, out_r, out_c;
  bit          all_in;
  int unsigned width_reg, height_reg, ksize_reg;
  blur_pix_t   pending_q[$];
  int unsigned mismatches, results_seen, frames_seen;

  function void reset_state();
    foreach (pix_store[i]) pix_store[i] = '0;
    width_reg  = 640;
    height_reg = 480;
    ksize_reg  = 10;
    restart();
  endfunction

  function void restart();
    in_r = 0; in_c = 0; out_r = 0; out_c = 0;
    all_in = 0;
  endfunction

  function int unsigned cur_w();
    return (width_reg < 1) ? 1 : (width_reg > cbb_pkg::MAX_WIDTH) ? cbb_pkg::MAX_WIDTH
                                                                     : width_reg;
  endfunction

  function int unsigned cur_h();
    return (height_reg < 1) ? 1 : (height_reg > cbb_pkg::ROW_LIMIT) ? cbb_pkg::ROW_LIMIT
                                                                       : height_reg;
  endfunction

  function int unsigned cur_half();
    return (ksize_reg / 2 > cbb_pkg::MAX_HALF) ? cbb_pkg::MAX_HALF : ksize_reg / 2;
  endfunction

  // Any valid register write restarts the frame; the line store keeps its contents.
  function void write_reg(logic [1:0] idx, logic [cbb_pkg::CFG_W-1:0] val);
    case (idx)
      cbb_pkg::REG_FRAME_WIDTH:  width_reg  = val;
      cbb_pkg::REG_FRAME_HEIGHT: height_reg = val;
      cbb_pkg::REG_KERNEL_SIZE:  ksize_reg  = val[3:0];
      default: return;
    endcase
    restart();
  endfunction

  function void predict_next(int unsigned w, int unsigned h, int unsigned hf);
    int unsigned r0, r1, c0, c1, sum, cnt;
    blur_pix_t   p;
    r0 = (out_r > hf) ? out_r - hf : 0;
    r1 = (out_r + hf > h - 1) ? h - 1 : out_r + hf;
    c0 = (out_c > hf) ? out_c - hf : 0;
    c1 = (out_c + hf > w - 1) ? w - 1 : out_c + hf;
    sum = 0;
    cnt = 0;
    for (int unsigned i = r0; i <= r1; i++)
      for (int unsigned j = c0; j <= c1; j++) begin
        sum += pix_store[(i * w + j) % cbb_pkg::STORE_DEPTH];
        cnt++;
      end
    p.mean = sum / cnt;
    p.last = (out_r == h - 1) && (out_c == w - 1);
    pending_q.push_back(p);
    if (p.last) begin
      restart();
      frames_seen++;
    end else if (out_c + 1 >= w) begin
      out_c = 0;
      out_r++;
    end else begin
      out_c++;
    end
  endfunction

  function void note_input(logic cmd, logic [cbb_pkg::PIX_W-1:0] pix);
    int unsigned w, h, hf, lag, n;
    w   = cur_w();
    h   = cur_h();
    hf  = cur_half();
    lag = hf * w + ((hf < w - 1) ? hf : w - 1);
    if (cmd) begin
      // An early drain does nothing.
      if (all_in) predict_next(w, h, hf);
      return;
    end
    // Pixels past the end of the frame are dropped.
    if (all_in) return;
    n = in_r * w + in_c;
    pix_store[n % cbb_pkg::STORE_DEPTH] = pix;
    if (in_r == h - 1 && in_c == w - 1) all_in = 1;
    else if (in_c + 1 >= w) begin
      in_c = 0;
      in_r++;
    end else in_c++;
    if (n >= lag) predict_next(w, h, hf);
  endfunction

  function void check(logic [cbb_pkg::PIX_W-1:0] mean, logic last);
    blur_pix_t p;
    results_seen++;
    if (pending_q.size() == 0) begin
      $error("unexpected result: mean_out=%0d frame_end=%0d", mean, last);
      mismatches++;
      return;
    end
    p = pending_q.pop_front();
    if (mean !== p.mean) begin
      $error("mean_out: expected %0d, got %0d", p.mean, mean);
      mismatches++;
    end
    if (last !== p.last) begin
      $error("frame_end: expected %0d, got %0d", p.last, last);
      mismatches++;
    end
  endfunction
endclass

module testbench;
  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 400;  // beyond the slowest single result

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [1:0] cfg_idx_i;
  logic [cbb_pkg::CFG_W-1:0] cfg_data_i;

  cbb_in_if  in_if ();
  cbb_out_if out_if ();

  clipped_box_blur_unit u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_if      (in_if.sink),
    .out_if     (out_if.source),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  blur_scoreboard blur_sb;
  int unsigned send_gap_pct;
  int unsigned take_stall_pct;
  int unsigned items_sent;
  int unsigned drains_sent;

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  // The receiver checks every accepted result and then decides its ready for the next edge.
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) blur_sb.check(out_if.mean_out, out_if.frame_end);
    out_if.ready <= ($urandom_range(99) >= take_stall_pct);
  end

  // Presents one item. Valid stays high after acceptance so that back-to-back items
  // carry no gap; the caller lowers it with stop_input when the stream pauses.
  task automatic send_item(logic cmd, logic [cbb_pkg::PIX_W-1:0] pix);
    while ($urandom_range(99) < send_gap_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid    <= 1'b1;
    in_if.cmd      <= cmd;
    in_if.pixel_in <= pix;
    do @(posedge clk_i); while (!in_if.ready);
    blur_sb.note_input(cmd, pix);
    items_sent++;
    if (cmd) drains_sent++;
  endtask

  task automatic stop_input();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // Waits until every predicted result has come back, plus time for work that yields none.
  task automatic settle();
    stop_input();
    while (blur_sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Back-to-back register writes keep the enable high; cfg_close lowers it.
  task automatic cfg_write(logic [1:0] idx, logic [cbb_pkg::CFG_W-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    blur_sb.write_reg(idx, val);
  endtask

  task automatic cfg_close();
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_phase(int unsigned sel);
    case (sel % 4)
      0: begin send_gap_pct = 0;  take_stall_pct = 0;  end
      1: begin send_gap_pct = 52; take_stall_pct = 0;  end
      2: begin send_gap_pct = 0;  take_stall_pct = 52; end
      default: begin send_gap_pct = 19; take_stall_pct = 19; end
    endcase
  endtask

  function automatic logic [cbb_pkg::PIX_W-1:0] rand_pix();
    case ($urandom_range(9))
      0: return 8'd0;
      1: return 8'd255;
      default: return cbb_pkg::PIX_W'($urandom_range(255));
    endcase
  endfunction

  // Runs one frame: configure, stream every pixel, then drain the trailing results.
  // With noise on, stray drains and surplus pixels are mixed in, and the frame may be
  // abandoned partway by a register write.
  task automatic run_frame(int unsigned w, int unsigned h, int unsigned k, bit noise);
    int unsigned npix;
    int unsigned cut;
    settle();
    cfg_write(cbb_pkg::REG_FRAME_WIDTH, cbb_pkg::CFG_W'(w));
    cfg_write(cbb_pkg::REG_FRAME_HEIGHT, cbb_pkg::CFG_W'(h));
    cfg_write(cbb_pkg::REG_KERNEL_SIZE, cbb_pkg::CFG_W'(k));
    if (noise && $urandom_range(7) == 0)
      cfg_write(REG_UNUSED, cbb_pkg::CFG_W'($urandom_range(2047)));
    cfg_close();
    npix = blur_sb.cur_w() * blur_sb.cur_h();
    cut  = (noise && $urandom_range(19) == 0) ? $urandom_range(npix) : npix + 1;
    for (int unsigned n = 0; n < npix; n++) begin
      if (n == cut) begin
        // A register write mid-frame abandons what has been sent so far.
        settle();
        cfg_write(cbb_pkg::REG_KERNEL_SIZE, cbb_pkg::CFG_W'($urandom_range(15)));
        cfg_close();
        return;
      end
      if (noise && $urandom_range(19) == 0) send_item(1'b1, rand_pix());
      send_item(1'b0, rand_pix());
    end
    while (blur_sb.all_in) begin
      if (noise && $urandom_range(15) == 0) send_item(1'b0, rand_pix());
      else send_item(1'b1, rand_pix());
    end
  endtask

  initial begin
    int unsigned frame_no;
    int unsigned w, h;
    blur_sb = new();
    blur_sb.reset_state();
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = cbb_pkg::REG_FRAME_WIDTH;
    cfg_data_i     = '0;
    in_if.valid    = 1'b0;
    in_if.cmd      = 1'b0;
    in_if.pixel_in = '0;
    out_if.ready   = 1'b0;
    send_gap_pct   = 0;
    take_stall_pct = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: a partial frame under the reset geometry, abandoned by a config write.
    for (int i = 0; i < 6; i++) send_item(1'b0, (i % 2) ? 8'd255 : 8'd0);
    // A 3x3 frame with a 3x3 window, a drain sent too early and a pixel after the last.
    settle();
    cfg_write(cbb_pkg::REG_FRAME_WIDTH, 11'd3);
    cfg_write(cbb_pkg::REG_FRAME_HEIGHT, 11'd3);
    cfg_write(cbb_pkg::REG_KERNEL_SIZE, 11'd2);
    cfg_close();
    send_item(1'b1, 8'd0);
    for (int i = 0; i < 9; i++) send_item(1'b0, (i % 3 == 1) ? 8'd0 : 8'd255);
    send_item(1'b0, 8'd77);
    while (blur_sb.all_in) send_item(1'b1, 8'd0);
    // Zero registers saturate to a single pixel with no neighbors.
    settle();
    cfg_write(cbb_pkg::REG_FRAME_WIDTH, 11'd0);
    cfg_write(cbb_pkg::REG_FRAME_HEIGHT, 11'd0);
    cfg_write(cbb_pkg::REG_KERNEL_SIZE, 11'd0);
    cfg_write(REG_UNUSED, 11'h7ff);
    cfg_close();
    send_item(1'b0, 8'd200);
    send_item(1'b1, 8'd0);
    // Oversized width: one full-width row with a single-pixel window, so every pixel
    // yields its result at once and frame_end lands on the clamped row end.
    set_phase(2);
    run_frame(2047, 1, 1, 1'b0);

    // Random frames, mostly small, a few wide ones; the idling phase rotates per frame.
    frame_no = 0;
    while (items_sent < 1350) begin
      set_phase(frame_no);
      case ($urandom_range(19))
        0: begin w = $urandom_range(100, 400); h = $urandom_range(1, 3); end
        1, 2: begin w = $urandom_range(17, 64); h = $urandom_range(1, 6); end
        default: begin w = $urandom_range(1, 16); h = $urandom_range(1, 12); end
      endcase
      run_frame(w, h, $urandom_range(15), 1'b1);
      frame_no++;
    end

    stop_input();
    while (blur_sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    $display("Sent %0d items (%0d drains) over %0d random frames; %0d results checked.",
             items_sent, drains_sent, frame_no, blur_sb.results_seen);
    $display("Finished frames: %0d, mismatches: %0d.", blur_sb.frames_seen, blur_sb.mismatches);
    if (blur_sb.mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #64_000_000;
    $display("Timed out with %0d results outstanding.", blur_sb.pending_q.size());
    $display("[FAIL] regression broken");
    $finish;
  end
endmodule
`default_nettype wire
